FILE: hw/rtl/flnta_pkg.sv
// Package for the fixed-length number to ASCII formatter.
// Holds the format codes, digit limits, ASCII constants and digit helpers.
// No dependencies.
`default_nettype none

package flnta_pkg;

    localparam int NumWidth   = 32;
    localparam int DecDigits  = 10;
    localparam int HexDigits  = 8;
    localparam int BcdWidth   = 4 * DecDigits;

    typedef enum logic [1:0] {
        FMT_UDEC = 2'd0,
        FMT_HEX  = 2'd1,
        FMT_SDEC = 2'd2,
        FMT_RSVD = 2'd3
    } fmt_t;

    localparam logic [6:0] ChZero  = 7'h30;
    localparam logic [6:0] ChUpA   = 7'h41;
    localparam logic [6:0] ChPlus  = 7'h2B;
    localparam logic [6:0] ChMinus = 7'h2D;

    localparam logic [3:0] DecMax = 4'd10;
    localparam logic [3:0] HexMax = 4'd8;

    // Double-dabble correction of one BCD digit before it is shifted.
    function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
        logic [3:0] r;
        r = (d >= 4'd5) ? d + 4'd3 : d;
        return r;
    endfunction

    // ASCII code of one hex or decimal digit.
    function automatic logic [6:0] digit_char(input logic [3:0] d);
        logic [6:0] r;
        if (d < 4'd10)
            r = ChZero + {3'b000, d};
        else
            r = ChUpA + {3'b000, d - 4'd10};
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/flnta_if.sv
// Handshake channels of the number to ASCII formatter: number items in,
// characters out. Depends on nothing but plain logic types.
`default_nettype none

interface flnta_num_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] number;
    logic [3:0]  digit_count;
    logic [2:0]  text_line;
    logic [4:0]  start_column;

    modport source (output valid, func, number, digit_count, text_line, start_column,
                    input ready);
    modport sink   (input valid, func, number, digit_count, text_line, start_column,
                    output ready);
endinterface

interface flnta_chr_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic [2:0] out_line;
    logic [4:0] out_column;
    logic       last_char;

    modport source (output valid, char_code, out_line, out_column, last_char,
                    input ready);
    modport sink   (input valid, char_code, out_line, out_column, last_char,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/fixed_length_number_to_ascii.sv
// Top level of the number to ASCII formatter: bit-serial binary to BCD
// conversion followed by a character emitter. Uses flnta_pkg and flnta_if.
//
//   Channel   Modport   Moves
//   num       sink      one number item (format, value, count, line, column)
//   chr       source    one ASCII character with line, column and last mark
//
// A decimal item is shifted through the shift-and-add-3 converter, one input
// bit per cycle, then emits one character per cycle while chr is not stalled;
// hex items skip the converter. A new item is taken only after the last
// character of the previous one has been produced. A stall on chr holds the
// emitter; the output register keeps the pending transfer. rst_n clears the
// control state asynchronously.
`default_nettype none

module fixed_length_number_to_ascii (
    input  wire          clk,
    input  wire          rst_n,
    flnta_num_if.sink    num,
    flnta_chr_if.source  chr
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    state_t                          state_reg, state_next;
    logic                            ovalid_reg, ovalid_next;
    logic [4:0]                      bitcnt_reg, bitcnt_next;
    logic [3:0]                      rem_reg, rem_next;
    logic                            signpend_reg, signpend_next;

    logic [flnta_pkg::NumWidth-1:0]  bin_reg, bin_next;
    logic [flnta_pkg::BcdWidth-1:0]  bcd_reg, bcd_next;
    logic                            neg_reg, neg_next;
    logic [2:0]                      line_reg, line_next;
    logic [4:0]                      col_reg, col_next;
    logic [6:0]                      ochar_reg, ochar_next;
    logic [2:0]                      oline_reg, oline_next;
    logic [4:0]                      ocol_reg, ocol_next;
    logic                            olast_reg, olast_next;

    logic                            take;
    logic                            slot_free;
    logic                            is_hex;
    logic                            is_sdec;
    logic [3:0]                      sat_count;
    logic [flnta_pkg::BcdWidth-1:0]  bcd_adj;
    logic [3:0]                      cur_digit;
    logic [3:0]                      digit_idx;

    assign num.ready = (state_reg == ST_IDLE);
    assign take      = num.valid && num.ready;
    assign slot_free = !ovalid_reg || chr.ready;

    assign is_hex  = (num.func == flnta_pkg::FMT_HEX);
    assign is_sdec = (num.func == flnta_pkg::FMT_SDEC);

    always_comb
    begin
        if (is_hex)
            sat_count = (num.digit_count > flnta_pkg::HexMax) ? flnta_pkg::HexMax
                                                               : num.digit_count;
        else
            sat_count = (num.digit_count > flnta_pkg::DecMax) ? flnta_pkg::DecMax
                                                               : num.digit_count;
    end

    // Every BCD digit gets its add-3 correction in parallel before the shift.
    always_comb
    begin
        for (int k = 0; k < flnta_pkg::DecDigits; k++)
            bcd_adj[4*k +: 4] = flnta_pkg::bcd_adjust(bcd_reg[4*k +: 4]);
    end

    assign digit_idx = rem_reg - 4'd1;

    always_comb
    begin
        cur_digit = 4'd0;
        for (int k = 0; k < flnta_pkg::DecDigits; k++)
            if (digit_idx == 4'(k))
                cur_digit = bcd_reg[4*k +: 4];
    end

    always_comb
    begin
        state_next    = state_reg;
        ovalid_next   = ovalid_reg;
        bitcnt_next   = bitcnt_reg;
        rem_next      = rem_reg;
        signpend_next = signpend_reg;
        bin_next      = bin_reg;
        bcd_next      = bcd_reg;
        neg_next      = neg_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        ochar_next    = ochar_reg;
        oline_next    = oline_reg;
        ocol_next     = ocol_reg;
        olast_next    = olast_reg;

        if (ovalid_reg && chr.ready)
            ovalid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    neg_next      = is_sdec && num.number[flnta_pkg::NumWidth-1];
                    bin_next      = (is_sdec && num.number[flnta_pkg::NumWidth-1])
                                    ? (~num.number + 32'd1) : num.number;
                    bcd_next      = '0;
                    bitcnt_next   = 5'd31;
                    rem_next      = sat_count;
                    signpend_next = is_sdec;
                    line_next     = num.text_line;
                    col_next      = num.start_column;
                    if (is_hex)
                    begin
                        bcd_next   = {8'h00, num.number};
                        state_next = (sat_count == 4'd0) ? ST_IDLE : ST_EMIT;
                    end
                    else if (sat_count == 4'd0 && !is_sdec)
                        state_next = ST_IDLE;
                    else
                        state_next = ST_CONV;
                end
            end

            ST_CONV:
            begin
                bcd_next    = {bcd_adj[flnta_pkg::BcdWidth-2:0],
                               bin_reg[flnta_pkg::NumWidth-1]};
                bin_next    = {bin_reg[flnta_pkg::NumWidth-2:0], 1'b0};
                bitcnt_next = bitcnt_reg - 5'd1;
                if (bitcnt_reg == 5'd0)
                    state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    oline_next  = line_reg;
                    ocol_next   = col_reg;
                    col_next    = col_reg + 5'd1;
                    if (signpend_reg)
                    begin
                        ochar_next    = neg_reg ? flnta_pkg::ChMinus : flnta_pkg::ChPlus;
                        olast_next    = (rem_reg == 4'd0);
                        signpend_next = 1'b0;
                        if (rem_reg == 4'd0)
                            state_next = ST_IDLE;
                    end
                    else
                    begin
                        ochar_next = flnta_pkg::digit_char(cur_digit);
                        olast_next = (rem_reg == 4'd1);
                        rem_next   = rem_reg - 4'd1;
                        if (rem_reg == 4'd1)
                            state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ovalid_reg   <= 1'b0;
            bitcnt_reg   <= '0;
            rem_reg      <= '0;
            signpend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ovalid_reg   <= ovalid_next;
            bitcnt_reg   <= bitcnt_next;
            rem_reg      <= rem_next;
            signpend_reg <= signpend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg   <= bin_next;
        bcd_reg   <= bcd_next;
        neg_reg   <= neg_next;
        line_reg  <= line_next;
        col_reg   <= col_next;
        ochar_reg <= ochar_next;
        oline_reg <= oline_next;
        ocol_reg  <= ocol_next;
        olast_reg <= olast_next;
    end

    assign chr.valid      = ovalid_reg;
    assign chr.char_code  = ochar_reg;
    assign chr.out_line   = oline_reg;
    assign chr.out_column = ocol_reg;
    assign chr.last_char  = olast_reg;

endmodule

`default_nettype wire
